### hw/rtl/gfd_pkg.sv
// ----------------------------------------------------------------------------
// gfd_pkg
// Shared types, widths and codes of the grid finite-difference stencil.
// ----------------------------------------------------------------------------
package gfd_pkg;

   // Default grid extent along each axis.
   localparam int GFD_X_SIZE = 16;
   localparam int GFD_Y_SIZE = 16;
   localparam int GFD_Z_SIZE = 16;

   // Field widths.
   localparam int COORD_W  = 4;
   localparam int SMP_W    = 18;              // Q1.16 sample part
   localparam int ENTRY_W  = 2 * SMP_W;       // {im, re}
   localparam int DIFF_W   = SMP_W + 3;       // next - 2*centre + prev
   localparam int COEF_W   = 32;              // Q16.16 coefficient
   localparam int HALF_W   = COEF_W / 2;
   localparam int FRAC_W   = 16;
   localparam int OPA_W    = 41;              // multiplier operand A
   localparam int ACC_W    = OPA_W + HALF_W + 1;
   localparam int RES_W    = 32;
   localparam int NUM_RES  = 4;
   localparam int RES_IDX_W = $clog2(NUM_RES);

   // Request payload layout, lowest bit first.
   localparam int X_LSB      = 0;
   localparam int Y_LSB      = X_LSB + COORD_W;
   localparam int Z_LSB      = Y_LSB + COORD_W;
   localparam int RE_LSB     = Z_LSB + COORD_W;
   localparam int IM_LSB     = RE_LSB + SMP_W;
   localparam int NORM_BIT   = IM_LSB + SMP_W;
   localparam int REQ_DATA_W = ((NORM_BIT + 1 + 7) / 8) * 8;
   localparam int RSP_DATA_W = NUM_RES * RES_W;

   // Request kinds carried on tuser.
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // Configuration registers.
   localparam int CSR_IDX_W = 3;
   localparam int NUM_REGS  = 7;
   localparam logic [CSR_IDX_W-1:0] REG_INV_DX_SQ   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INV_DY_SQ   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INV_DZ_SQ   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HALF_INV_DX = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_HALF_INV_DY = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_HALF_INV_DZ = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_AMP_FACTOR  = 3'd6;

   localparam logic [COEF_W-1:0] INV_SQ_RESET   = 32'd65536;
   localparam logic [COEF_W-1:0] HALF_INV_RESET = 32'd32768;
   localparam logic [COEF_W-1:0] AMP_RESET      = 32'd65536;

   // Operations of the shared multiply-accumulate unit.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_MAC_HI,
      OP_MAC_LO,
      OP_ROUND,
      OP_NORM_HI,
      OP_NORM_LO
   } op_type;

   typedef struct packed {
      op_type                 op;
      logic                   clear;
      logic                   store;
      logic [RES_IDX_W-1:0]   res_idx;
   } alu_ctl_type;

endpackage

### hw/rtl/gfd_grid_ram.sv
// ----------------------------------------------------------------------------
// gfd_grid_ram
// Amplitude grid storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gfd_grid_ram #(
   parameter int ADDR_W = 12
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [ADDR_W-1:0]            wr_addr,
   input  logic [gfd_pkg::ENTRY_W-1:0]  wr_data,
   input  logic [ADDR_W-1:0]            rd_addr,
   output logic [gfd_pkg::ENTRY_W-1:0]  rd_data
);
   import gfd_pkg::*;

   localparam int DEPTH = 2 ** ADDR_W;

   logic [ENTRY_W-1:0] mem_ff [DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/gfd_alu.sv
// ----------------------------------------------------------------------------
// gfd_alu
// Shared multiply-accumulate unit with rounding, scaling and saturation.
// ----------------------------------------------------------------------------
module gfd_alu (
   input  logic                                          clock,
   input  logic                                          reset,
   input  gfd_pkg::alu_ctl_type                          issue_ctl,
   input  logic signed [gfd_pkg::OPA_W-1:0]              issue_opa,
   input  logic [gfd_pkg::HALF_W-1:0]                    issue_opb,
   output logic [gfd_pkg::NUM_RES-1:0][gfd_pkg::RES_W-1:0] result
);
   import gfd_pkg::*;

   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(2 ** (FRAC_W - 1));

   function automatic logic signed [ACC_W-1:0] round16(input logic signed [ACC_W-1:0] val);
      logic signed [ACC_W-1:0] sum;
      sum = val + ROUND_HALF;
      return sum >>> FRAC_W;
   endfunction

   function automatic logic [RES_W-1:0] saturate(input logic signed [ACC_W-1:0] val);
      logic [ACC_W-RES_W:0] upper;
      upper = val[ACC_W-1:RES_W-1];
      if ((upper == '0) || (upper == '1)) begin
         return val[RES_W-1:0];
      end
      return val[ACC_W-1] ? {1'b1, {(RES_W-1){1'b0}}} : {1'b0, {(RES_W-1){1'b1}}};
   endfunction

   alu_ctl_type                ctl0_ff, ctl1_ff;
   logic signed [OPA_W-1:0]    opa0_ff;
   logic [HALF_W-1:0]          opb0_ff;
   logic signed [OPA_W-1:0]    v_ff;
   logic signed [ACC_W-1:0]    prod_ff, prod_in;
   logic signed [ACC_W-1:0]    acc_ff;
   logic signed [ACC_W-1:0]    acc_base;
   logic signed [ACC_W-1:0]    rnd_acc, rnd_prod, norm_sum;
   logic signed [OPA_W-1:0]    mul_a;
   logic signed [HALF_W:0]     mul_b;
   logic [NUM_RES-1:0][RES_W-1:0] res_ff;

   // Scaling steps multiply the rounded value kept from the previous step.
   always_comb begin
      mul_a    = ((ctl0_ff.op == OP_NORM_HI) || (ctl0_ff.op == OP_NORM_LO)) ? v_ff : opa0_ff;
      mul_b    = {1'b0, opb0_ff};
      prod_in  = mul_a * mul_b;
      acc_base = ctl1_ff.clear ? '0 : acc_ff;
      rnd_acc  = round16(acc_ff);
      rnd_prod = round16(prod_ff);
      norm_sum = acc_ff + rnd_prod;
   end

   // Only the operation codes are reset; the data path follows them.
   always_ff @(posedge clock) begin
      ctl0_ff.op      <= reset ? OP_NONE : issue_ctl.op;
      ctl1_ff.op      <= reset ? OP_NONE : ctl0_ff.op;
      ctl0_ff.clear   <= issue_ctl.clear;
      ctl0_ff.store   <= issue_ctl.store;
      ctl0_ff.res_idx <= issue_ctl.res_idx;
      opa0_ff         <= issue_opa;
      opb0_ff         <= issue_opb;
      ctl1_ff.clear   <= ctl0_ff.clear;
      ctl1_ff.store   <= ctl0_ff.store;
      ctl1_ff.res_idx <= ctl0_ff.res_idx;
      prod_ff         <= prod_in;
      case (ctl1_ff.op)
         OP_MAC_HI: begin
            acc_ff <= acc_base + (prod_ff <<< FRAC_W);
         end
         OP_MAC_LO: begin
            acc_ff <= acc_base + prod_ff;
         end
         OP_ROUND: begin
            v_ff <= rnd_acc[OPA_W-1:0];
            if (ctl1_ff.store) begin
               res_ff[ctl1_ff.res_idx] <= saturate(rnd_acc);
            end
         end
         OP_NORM_HI: begin
            acc_ff <= prod_ff;
         end
         OP_NORM_LO: begin
            res_ff[ctl1_ff.res_idx] <= saturate(norm_sum);
         end
         default: begin
         end
      endcase
   end

   assign result = res_ff;

endmodule

### hw/rtl/grid_finite_difference_stencil.sv
// ----------------------------------------------------------------------------
// grid_finite_difference_stencil
// Seven-point Laplacian and summed central-difference gradient on a 3D grid.
// ----------------------------------------------------------------------------
// Loads may follow back to back.
// A query blocks new requests until its response is raised on rsp_tvalid: the
// seven taps are read on the single memory read port, then each result takes its
// shared-multiplier issue slots, plus the scale slots with normalize, then the
// unit's pipeline drains.
// Synchronous reset restores the coefficients and idles the sequencer; no grid clear.
// ----------------------------------------------------------------------------
module grid_finite_difference_stencil #(
   parameter int X_SIZE = gfd_pkg::GFD_X_SIZE,
   parameter int Y_SIZE = gfd_pkg::GFD_Y_SIZE,
   parameter int Z_SIZE = gfd_pkg::GFD_Z_SIZE
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata from bit 0: x_pos[4], y_pos[4], z_pos[4], sample_re[18],
   // sample_im[18], normalize[1], zero padding.
   input  logic [gfd_pkg::REQ_DATA_W-1:0]    req_tdata,
   // tuser: kind[1] (0 load, 1 query).
   input  logic                              req_tuser,
   // Response channel.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata from bit 0: lap_re[32], lap_im[32], grad_re[32], grad_im[32].
   output logic [gfd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // Configuration write port.
   input  logic                              csr_wr_en,
   input  logic [gfd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gfd_pkg::COEF_W-1:0]        csr_wdata
);
   import gfd_pkg::*;

   // Coordinates are four bits wide, so only the first 16 points of any
   // axis can be addressed.
   localparam int COORD_LIM = 2 ** COORD_W;
   localparam int XS_EFF = (X_SIZE < COORD_LIM) ? X_SIZE : COORD_LIM;
   localparam int YS_EFF = (Y_SIZE < COORD_LIM) ? Y_SIZE : COORD_LIM;
   localparam int ZS_EFF = (Z_SIZE < COORD_LIM) ? Z_SIZE : COORD_LIM;
   localparam int XB = $clog2(XS_EFF);
   localparam int YB = $clog2(YS_EFF);
   localparam int ZB = $clog2(ZS_EFF);
   localparam int ADDR_W = XB + YB + ZB;
   localparam int CX_W = COORD_W + 1;

   // Order in which the stencil taps are read and stored.
   localparam logic [2:0] TAP_CENTER = 3'd0;
   localparam logic [2:0] TAP_XP     = 3'd1;
   localparam logic [2:0] TAP_XM     = 3'd2;
   localparam logic [2:0] TAP_YP     = 3'd3;
   localparam logic [2:0] TAP_YM     = 3'd4;
   localparam logic [2:0] TAP_ZP     = 3'd5;
   localparam logic [2:0] TAP_ZM     = 3'd6;
   localparam logic [2:0] TAP_LAST   = 3'd7;
   localparam int NUM_TAPS = 7;

   // Issue slots of one result: six multiply-accumulate slots, then round,
   // a gap while the rounded value is registered, then the two scale slots.
   localparam logic [3:0] STEP_ROUND = 4'd6;
   localparam logic [3:0] STEP_NHI   = 4'd8;
   localparam logic [3:0] STEP_NLO   = 4'd9;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CALC,
      ST_DRAIN,
      ST_OUT
   } state_type;

   function automatic logic in_grid(input logic [CX_W-1:0] cx, input logic [CX_W-1:0] cy,
                                    input logic [CX_W-1:0] cz);
      return (cx < CX_W'(XS_EFF)) && (cy < CX_W'(YS_EFF)) && (cz < CX_W'(ZS_EFF));
   endfunction

   function automatic logic [ADDR_W-1:0] grid_addr(input logic [CX_W-1:0] cx,
                                                   input logic [CX_W-1:0] cy,
                                                   input logic [CX_W-1:0] cz);
      return {cx[XB-1:0], cy[YB-1:0], cz[ZB-1:0]};
   endfunction

   function automatic logic signed [DIFF_W-1:0] sx(input logic [SMP_W-1:0] val);
      return {{(DIFF_W-SMP_W){val[SMP_W-1]}}, val};
   endfunction

   state_type               state_ff;
   logic [2:0]              rd_cnt_ff;
   logic [1:0]              job_ff;
   logic [3:0]              step_ff;
   logic                    drain_ff;
   logic                    cap_ff;
   logic [2:0]              tap_idx_ff;
   logic                    tap_ok_ff;
   logic [COORD_W-1:0]      qx_ff, qy_ff, qz_ff;
   logic                    qnorm_ff;
   logic [ENTRY_W-1:0]      smp_ff [NUM_TAPS];
   logic [COEF_W-1:0]       cfg_ff [NUM_REGS];
   logic                    rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0]   rsp_tdata_ff;

   logic                    req_xfer;
   logic [CX_W-1:0]         ld_x, ld_y, ld_z;
   logic                    ram_wr_en;
   logic [ENTRY_W-1:0]      ram_wr_data;
   logic [CX_W-1:0]         tx, ty, tz;
   logic                    tap_in;
   logic [ADDR_W-1:0]       ram_rd_addr;
   logic [ENTRY_W-1:0]      ram_rd_data;
   logic                    last_step;

   alu_ctl_type             issue_ctl;
   logic signed [OPA_W-1:0] issue_opa;
   logic [HALF_W-1:0]       issue_opb;
   logic [1:0]              axis;
   logic [ENTRY_W-1:0]      e_next, e_prev, e_cent;
   logic [SMP_W-1:0]        s_next, s_prev, s_cent;
   logic signed [DIFF_W-1:0] diff;
   logic [CSR_IDX_W-1:0]    coef_idx;
   logic [COEF_W-1:0]       coef;
   logic [NUM_RES-1:0][RES_W-1:0] alu_result;

   // The block takes a request only while the sequencer is idle; a finished
   // response may still be waiting on the output register at that time.
   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;

   // A load writes straight into the grid in the cycle of its transfer.
   // Points beyond the grid are dropped.
   assign ld_x        = {1'b0, req_tdata[X_LSB +: COORD_W]};
   assign ld_y        = {1'b0, req_tdata[Y_LSB +: COORD_W]};
   assign ld_z        = {1'b0, req_tdata[Z_LSB +: COORD_W]};
   assign ram_wr_en   = req_xfer && (req_tuser == KIND_LOAD) && in_grid(ld_x, ld_y, ld_z);
   assign ram_wr_data = {req_tdata[IM_LSB +: SMP_W], req_tdata[RE_LSB +: SMP_W]};

   // Tap coordinates. The five-bit arithmetic wraps a step below zero to a
   // large value, so one compare against the grid size covers both edges.
   always_comb begin
      tx = {1'b0, qx_ff};
      ty = {1'b0, qy_ff};
      tz = {1'b0, qz_ff};
      case (rd_cnt_ff)
         TAP_XP:  tx = tx + 1'b1;
         TAP_XM:  tx = tx - 1'b1;
         TAP_YP:  ty = ty + 1'b1;
         TAP_YM:  ty = ty - 1'b1;
         TAP_ZP:  tz = tz + 1'b1;
         TAP_ZM:  tz = tz - 1'b1;
         default: begin
         end
      endcase
      tap_in      = in_grid(tx, ty, tz);
      ram_rd_addr = grid_addr(tx, ty, tz);
   end

   gfd_grid_ram #(
      .ADDR_W  (ADDR_W)
   ) u_grid_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (grid_addr(ld_x, ld_y, ld_z)),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Operand selection for the shared unit. Job bit 1 picks Laplacian or
   // gradient, job bit 0 picks the real or imaginary part; the job number is
   // also the response slot, which matches the tdata order.
   always_comb begin
      axis = step_ff[2:1];
      e_cent = smp_ff[TAP_CENTER];
      case (axis)
         2'd0: begin
            e_next = smp_ff[TAP_XP];
            e_prev = smp_ff[TAP_XM];
         end
         2'd1: begin
            e_next = smp_ff[TAP_YP];
            e_prev = smp_ff[TAP_YM];
         end
         default: begin
            e_next = smp_ff[TAP_ZP];
            e_prev = smp_ff[TAP_ZM];
         end
      endcase
      s_next = job_ff[0] ? e_next[ENTRY_W-1:SMP_W] : e_next[SMP_W-1:0];
      s_prev = job_ff[0] ? e_prev[ENTRY_W-1:SMP_W] : e_prev[SMP_W-1:0];
      s_cent = job_ff[0] ? e_cent[ENTRY_W-1:SMP_W] : e_cent[SMP_W-1:0];
      if (job_ff[1]) begin
         diff = sx(s_next) - sx(s_prev);
      end else begin
         diff = sx(s_next) + sx(s_prev) - (sx(s_cent) <<< 1);
      end
      coef_idx = job_ff[1] ? (REG_HALF_INV_DX + {1'b0, axis}) : (REG_INV_DX_SQ + {1'b0, axis});
      coef     = cfg_ff[coef_idx];

      issue_ctl.op      = OP_NONE;
      issue_ctl.clear   = (step_ff == '0);
      issue_ctl.store   = 1'b0;
      issue_ctl.res_idx = job_ff;
      issue_opa         = {{(OPA_W-DIFF_W){diff[DIFF_W-1]}}, diff};
      // Each coefficient is split into its upper and lower halves so that
      // the multiplier stays narrow; the upper product is weighted by 2^16.
      issue_opb         = step_ff[0] ? coef[HALF_W-1:0] : coef[COEF_W-1:HALF_W];
      last_step         = 1'b0;
      if (state_ff == ST_CALC) begin
         if (step_ff < STEP_ROUND) begin
            issue_ctl.op = step_ff[0] ? OP_MAC_LO : OP_MAC_HI;
         end else begin
            case (step_ff)
               STEP_ROUND: begin
                  issue_ctl.op    = OP_ROUND;
                  issue_ctl.store = !qnorm_ff;
                  last_step       = !qnorm_ff;
               end
               STEP_NHI: begin
                  issue_ctl.op = OP_NORM_HI;
                  issue_opb    = cfg_ff[REG_AMP_FACTOR][COEF_W-1:HALF_W];
               end
               STEP_NLO: begin
                  issue_ctl.op    = OP_NORM_LO;
                  issue_ctl.store = 1'b1;
                  issue_opb       = cfg_ff[REG_AMP_FACTOR][HALF_W-1:0];
                  last_step       = 1'b1;
               end
               default: begin
               end
            endcase
         end
      end
   end

   gfd_alu u_alu (
      .clock     (clock),
      .reset     (reset),
      .issue_ctl (issue_ctl),
      .issue_opa (issue_opa),
      .issue_opb (issue_opb),
      .result    (alu_result)
   );

   // Sequencer: idle, seven grid reads, the issue slots of four results, a drain
   // of the unit's pipeline, then the response.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_cnt_ff     <= '0;
         job_ff        <= '0;
         step_ff       <= '0;
         drain_ff      <= 1'b0;
         cap_ff        <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         cap_ff <= (state_ff == ST_READ) && (rd_cnt_ff != TAP_LAST);
         // In the output state the response register is handled below.
         if (rsp_tvalid_ff && rsp_tready && (state_ff != ST_OUT)) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_xfer && (req_tuser == KIND_QUERY)) begin
                  rd_cnt_ff <= '0;
                  state_ff  <= ST_READ;
               end
            end
            ST_READ: begin
               rd_cnt_ff <= rd_cnt_ff + 1'b1;
               if (rd_cnt_ff == TAP_LAST) begin
                  job_ff   <= '0;
                  step_ff  <= '0;
                  state_ff <= ST_CALC;
               end
            end
            ST_CALC: begin
               if (last_step) begin
                  step_ff <= '0;
                  job_ff  <= job_ff + 1'b1;
                  if (job_ff == 2'(NUM_RES - 1)) begin
                     drain_ff <= 1'b0;
                     state_ff <= ST_DRAIN;
                  end
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_DRAIN: begin
               drain_ff <= 1'b1;
               if (drain_ff) begin
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tdata_ff  <= alu_result;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Query coordinates and the read pipeline. A tap beyond the grid is
   // stored as zero, whatever the memory returned for it.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         qx_ff    <= req_tdata[X_LSB +: COORD_W];
         qy_ff    <= req_tdata[Y_LSB +: COORD_W];
         qz_ff    <= req_tdata[Z_LSB +: COORD_W];
         qnorm_ff <= req_tdata[NORM_BIT];
      end
      tap_idx_ff <= rd_cnt_ff;
      tap_ok_ff  <= tap_in;
      if (cap_ff) begin
         smp_ff[tap_idx_ff] <= tap_ok_ff ? ram_rd_data : '0;
      end
   end

   // Coefficient registers. Writes to an index beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[REG_INV_DX_SQ]   <= INV_SQ_RESET;
         cfg_ff[REG_INV_DY_SQ]   <= INV_SQ_RESET;
         cfg_ff[REG_INV_DZ_SQ]   <= INV_SQ_RESET;
         cfg_ff[REG_HALF_INV_DX] <= HALF_INV_RESET;
         cfg_ff[REG_HALF_INV_DY] <= HALF_INV_RESET;
         cfg_ff[REG_HALF_INV_DZ] <= HALF_INV_RESET;
         cfg_ff[REG_AMP_FACTOR]  <= AMP_RESET;
      end else if (csr_wr_en && (csr_index < CSR_IDX_W'(NUM_REGS))) begin
         cfg_ff[csr_index] <= csr_wdata;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

### dv/gfd_stencil_checker.sv
// ----------------------------------------------------------------------------
// gfd_stencil_checker
// Watches the request, response and register ports of the stencil block,
// keeps its own grid and coefficients, and compares every response word
// with the value it works out for the matching query.
// ----------------------------------------------------------------------------
module gfd_stencil_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   // tdata from bit 0: x_pos[4], y_pos[4], z_pos[4], sample_re[18],
   // sample_im[18], normalize[1], zero padding.
   input  logic [gfd_pkg::REQ_DATA_W-1:0] req_tdata,
   // tuser: kind[1].
   input  logic                           req_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // tdata from bit 0: lap_re[32], lap_im[32], grad_re[32], grad_im[32].
   input  logic [gfd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_wr_en,
   input  logic [gfd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gfd_pkg::COEF_W-1:0]     csr_wdata,
   output int                             mismatches,
   output int                             owed
);
   timeunit 1ns;
   timeprecision 1ps;
   import gfd_pkg::*;

   // Packed so that the layout matches rsp_tdata, lap_re in the lowest bits.
   typedef struct packed {
      logic [RES_W-1:0] grad_im;
      logic [RES_W-1:0] grad_re;
      logic [RES_W-1:0] lap_im;
      logic [RES_W-1:0] lap_re;
   } stencil_result_type;

   localparam int     GRID_POINTS = GFD_X_SIZE * GFD_Y_SIZE * GFD_Z_SIZE;
   localparam longint SAT_HI      = 64'sd2147483647;
   localparam longint SAT_LO      = -64'sd2147483648;
   localparam longint HALF_LSB    = 64'sd32768;

   logic signed [SMP_W-1:0] amp_re [GRID_POINTS];
   logic signed [SMP_W-1:0] amp_im [GRID_POINTS];
   logic [COEF_W-1:0]       inv_sq [3];
   logic [COEF_W-1:0]       half_inv [3];
   logic [COEF_W-1:0]       amp_factor;
   stencil_result_type      owed_results [$];
   int                      results_seen;
   string                   field_name [NUM_RES] = '{"lap_re", "lap_im", "grad_re", "grad_im"};

   // Points off the grid read as zero.
   function automatic longint sample_at(int x, int y, int z, bit imag);
      int slot;
      if (x < 0 || x >= GFD_X_SIZE || y < 0 || y >= GFD_Y_SIZE || z < 0 || z >= GFD_Z_SIZE)
         return 0;
      slot = (x * GFD_Y_SIZE + y) * GFD_Z_SIZE + z;
      return imag ? longint'(amp_im[slot]) : longint'(amp_re[slot]);
   endfunction

   // Round the Q.32 sum to Q.16, apply the optional amplitude factor in two
   // halves so nothing overflows 64 bits, then clamp to 32 signed bits.
   function automatic logic [RES_W-1:0] settle(longint acc, bit norm);
      longint v;
      v = (acc + HALF_LSB) >>> FRAC_W;
      if (norm)
         v = v * longint'(amp_factor[COEF_W-1:HALF_W])
             + ((v * longint'(amp_factor[HALF_W-1:0]) + HALF_LSB) >>> FRAC_W);
      if (v > SAT_HI)
         v = SAT_HI;
      else if (v < SAT_LO)
         v = SAT_LO;
      return v[RES_W-1:0];
   endfunction

   function automatic stencil_result_type stencil_at(int x, int y, int z, bit norm);
      stencil_result_type r;
      longint             center, nxt, prv, lap, grad;
      int                 sx, sy, sz;
      logic [RES_W-1:0]   lap_w [2];
      logic [RES_W-1:0]   grad_w [2];
      for (int part = 0; part < 2; part++) begin
         center = sample_at(x, y, z, 1'(part));
         lap    = 0;
         grad   = 0;
         for (int a = 0; a < 3; a++) begin
            sx   = (a == 0) ? 1 : 0;
            sy   = (a == 1) ? 1 : 0;
            sz   = (a == 2) ? 1 : 0;
            nxt  = sample_at(x + sx, y + sy, z + sz, 1'(part));
            prv  = sample_at(x - sx, y - sy, z - sz, 1'(part));
            lap  += (nxt - 2 * center + prv) * longint'(inv_sq[a]);
            grad += (nxt - prv) * longint'(half_inv[a]);
         end
         lap_w[part]  = settle(lap, norm);
         grad_w[part] = settle(grad, norm);
      end
      r.lap_re  = lap_w[0];
      r.lap_im  = lap_w[1];
      r.grad_re = grad_w[0];
      r.grad_im = grad_w[1];
      return r;
   endfunction

   always @(posedge clock) begin : watch
      stencil_result_type want;
      logic [COORD_W-1:0] qx, qy, qz;
      int                 slot;
      if (reset) begin
         inv_sq[0]    = INV_SQ_RESET;
         inv_sq[1]    = INV_SQ_RESET;
         inv_sq[2]    = INV_SQ_RESET;
         half_inv[0]  = HALF_INV_RESET;
         half_inv[1]  = HALF_INV_RESET;
         half_inv[2]  = HALF_INV_RESET;
         amp_factor   = AMP_RESET;
         owed_results.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_INV_DX_SQ:   inv_sq[0]   = csr_wdata;
               REG_INV_DY_SQ:   inv_sq[1]   = csr_wdata;
               REG_INV_DZ_SQ:   inv_sq[2]   = csr_wdata;
               REG_HALF_INV_DX: half_inv[0] = csr_wdata;
               REG_HALF_INV_DY: half_inv[1] = csr_wdata;
               REG_HALF_INV_DZ: half_inv[2] = csr_wdata;
               REG_AMP_FACTOR:  amp_factor  = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            qx = req_tdata[X_LSB +: COORD_W];
            qy = req_tdata[Y_LSB +: COORD_W];
            qz = req_tdata[Z_LSB +: COORD_W];
            if (req_tuser == KIND_LOAD) begin
               slot         = (int'(qx) * GFD_Y_SIZE + int'(qy)) * GFD_Z_SIZE + int'(qz);
               amp_re[slot] = req_tdata[RE_LSB +: SMP_W];
               amp_im[slot] = req_tdata[IM_LSB +: SMP_W];
            end else begin
               owed_results.push_back(stencil_at(int'(qx), int'(qy), int'(qz),
                                                 req_tdata[NORM_BIT]));
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (owed_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response %0d arrived with no query pending: %h",
                           results_seen, rsp_tdata);
            end else begin
               want = owed_results.pop_front();
               for (int k = 0; k < NUM_RES; k++) begin
                  if (rsp_tdata[k*RES_W +: RES_W] !== want[k*RES_W +: RES_W]) begin
                     mismatches++;
                     if (mismatches <= 10)
                        $display("response %0d %s: expected %h, got %h", results_seen,
                                 field_name[k], want[k*RES_W +: RES_W],
                                 rsp_tdata[k*RES_W +: RES_W]);
                  end
               end
            end
            results_seen++;
         end
      end
      owed = owed_results.size();
   end

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives loads and queries into the 3D stencil block under bursty traffic and
// a stalling response side, reprograms the coefficients between phases, and
// reports the verdict from the failure count of the stencil checker.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import gfd_pkg::*;

   // Index one past the register file; writes to it must change nothing.
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED = 3'd7;
   // Most positive and most negative Q1.16 sample.
   localparam logic [SMP_W-1:0] SMP_MAX = 18'h1FFFF;
   localparam logic [SMP_W-1:0] SMP_MIN = 18'h20000;
   // Settling wait when draining, kept longer than a normalized query.
   localparam int SETTLE_CYCLES = 64;
   // Six coefficient phases of this many transfers each, auto-loads included.
   localparam int PHASE_ITEMS   = 215;
   localparam int GRID_POINTS   = GFD_X_SIZE * GFD_Y_SIZE * GFD_Z_SIZE;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // tdata from bit 0: x_pos[4], y_pos[4], z_pos[4], sample_re[18],
   // sample_im[18], normalize[1], zero padding.
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   // tuser: kind[1] (0 load, 1 query).
   logic                  req_tuser  = KIND_LOAD;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // tdata from bit 0: lap_re[32], lap_im[32], grad_re[32], grad_im[32].
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wr_en  = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [COEF_W-1:0]     csr_wdata  = '0;

   int mismatches;
   int owed;

   // Which grid points hold a sample. A query is only issued once its center
   // and every neighbor inside the grid has been loaded, since reading an
   // entry that was never written is outside the contract of the block.
   bit loaded [GRID_POINTS];
   int burst_left = 0;
   int items_sent = 0;
   int tready_hold = 0;

   grid_finite_difference_stencil dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   gfd_stencil_checker stencil_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .owed       (owed)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // The response side switches between stretches of free flow, long stalls
   // and a coin toss every cycle, so the output register is held under
   // back-pressure in varied patterns.
   always @(posedge clock) begin
      if (tready_hold != 0) begin
         tready_hold <= tready_hold - 1;
      end else begin
         case ($urandom_range(0, 3))
            0: begin
               rsp_tready  <= 1'b1;
               tready_hold <= $urandom_range(5, 80);
            end
            1: begin
               rsp_tready  <= 1'b0;
               tready_hold <= $urandom_range(1, 20);
            end
            default: begin
               rsp_tready  <= 1'($urandom_range(0, 1));
               tready_hold <= 0;
            end
         endcase
      end
   end

   // One request transfer. The sender runs in bursts of random length; at the
   // start of each burst it may sit idle for a random gap. tvalid stays high
   // from one transfer to the next inside a burst.
   task automatic push_item(input logic kind, input logic [COORD_W-1:0] x, y, z,
                            input logic [SMP_W-1:0] re, im, input logic norm);
      logic [REQ_DATA_W-1:0] word;
      int                    gap;
      word = '0;
      word[X_LSB +: COORD_W]  = x;
      word[Y_LSB +: COORD_W]  = y;
      word[Z_LSB +: COORD_W]  = z;
      word[RE_LSB +: SMP_W]   = re;
      word[IM_LSB +: SMP_W]   = im;
      word[NORM_BIT]          = norm;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (kind == KIND_LOAD)
         loaded[(x * GFD_Y_SIZE + y) * GFD_Z_SIZE + z] = 1'b1;
      items_sent++;
   endtask

   // Pause the sender until every query has been answered, then leave the
   // block alone long enough for any trailing load to land in the grid.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(negedge clock); while (owed != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [COEF_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic program_coefs(input logic [COEF_W-1:0] sq_x, sq_y, sq_z,
                                input logic [COEF_W-1:0] hf_x, hf_y, hf_z, amp);
      write_reg(REG_INV_DX_SQ, sq_x);
      write_reg(REG_INV_DY_SQ, sq_y);
      write_reg(REG_INV_DZ_SQ, sq_z);
      write_reg(REG_HALF_INV_DX, hf_x);
      write_reg(REG_HALF_INV_DY, hf_y);
      write_reg(REG_HALF_INV_DZ, hf_z);
      write_reg(REG_AMP_FACTOR, amp);
      csr_wr_en <= 1'b0;
   endtask

   // Samples lean on the extremes so the difference terms reach their limits.
   function automatic logic [SMP_W-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0:       return SMP_MAX;
         1:       return SMP_MIN;
         2:       return '0;
         3:       return '1;
         default: return SMP_W'($urandom_range(0, (1 << SMP_W) - 1));
      endcase
   endfunction

   // At least a quarter of the coordinates sit on a face of the grid, where some
   // neighbors fall outside and read as zero.
   function automatic logic [COORD_W-1:0] pick_coord();
      if ($urandom_range(0, 3) == 0)
         return $urandom_range(0, 1) ? 4'd15 : 4'd0;
      return COORD_W'($urandom_range(0, 15));
   endfunction

   task automatic load_point(input int x, y, z);
      push_item(KIND_LOAD, COORD_W'(x), COORD_W'(y), COORD_W'(z), pick_sample(), pick_sample(),
                1'($urandom_range(0, 1)));
   endtask

   // A well-formed query: fill in any neighbor that has never been loaded,
   // then ask. The sample fields carry junk, which the block must ignore.
   task automatic query_point(input int x, y, z, input logic norm);
      int nx, ny, nz;
      for (int dx = -1; dx <= 1; dx++) begin
         for (int dy = -1; dy <= 1; dy++) begin
            for (int dz = -1; dz <= 1; dz++) begin
               nx = x + dx;
               ny = y + dy;
               nz = z + dz;
               if ((dx != 0) + (dy != 0) + (dz != 0) <= 1
                   && nx >= 0 && nx < GFD_X_SIZE && ny >= 0 && ny < GFD_Y_SIZE
                   && nz >= 0 && nz < GFD_Z_SIZE
                   && !loaded[(nx * GFD_Y_SIZE + ny) * GFD_Z_SIZE + nz])
                  load_point(nx, ny, nz);
            end
         end
      end
      push_item(KIND_QUERY, COORD_W'(x), COORD_W'(y), COORD_W'(z), pick_sample(), pick_sample(),
                norm);
   endtask

   // Mostly queries with their loads, the rest stray loads that overwrite
   // points already in use, and now and then a full drain of the pipeline.
   task automatic run_random(input int quota);
      int start;
      int roll;
      start = items_sent;
      while (items_sent - start < quota) begin
         roll = $urandom_range(0, 99);
         if (roll < 60)
            query_point(int'(pick_coord()), int'(pick_coord()), int'(pick_coord()),
                        1'($urandom_range(0, 1)));
         else if (roll < 98)
            load_point(int'(pick_coord()), int'(pick_coord()), int'(pick_coord()));
         else
            wait_idle();
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Origin corner: three neighbors lie off the grid. The center and its
      // in-grid neighbors carry opposite extremes, so every difference term
      // is as large as it gets. The load sets normalize, which must be ignored.
      push_item(KIND_LOAD, 0, 0, 0, SMP_MAX, SMP_MIN, 1'b1);
      push_item(KIND_LOAD, 1, 0, 0, SMP_MIN, SMP_MAX, 1'b0);
      push_item(KIND_LOAD, 0, 1, 0, SMP_MIN, SMP_MAX, 1'b0);
      push_item(KIND_LOAD, 0, 0, 1, SMP_MIN, SMP_MAX, 1'b0);
      push_item(KIND_QUERY, 0, 0, 0, SMP_MAX, SMP_MAX, 1'b0);
      push_item(KIND_QUERY, 0, 0, 0, SMP_MIN, SMP_MIN, 1'b1);
      // Far corner, signs swapped.
      push_item(KIND_LOAD, 15, 15, 15, SMP_MIN, SMP_MAX, 1'b0);
      push_item(KIND_LOAD, 14, 15, 15, SMP_MAX, SMP_MIN, 1'b1);
      push_item(KIND_LOAD, 15, 14, 15, SMP_MAX, SMP_MIN, 1'b0);
      push_item(KIND_LOAD, 15, 15, 14, SMP_MAX, SMP_MIN, 1'b1);
      push_item(KIND_QUERY, 15, 15, 15, '0, '1, 1'b0);
      push_item(KIND_QUERY, 15, 15, 15, '1, '0, 1'b1);
      // Overwrite the origin with zero and ask again.
      push_item(KIND_LOAD, 0, 0, 0, '0, '0, 1'b0);
      push_item(KIND_QUERY, 0, 0, 0, SMP_MAX, SMP_MIN, 1'b0);

      // Coefficients at their reset values.
      run_random(PHASE_ITEMS);

      // Everything at full scale: most results saturate. A write to the
      // index past the register file goes first and must change nothing.
      wait_idle();
      write_reg(REG_UNMAPPED, '1);
      program_coefs('1, '1, '1, '1, '1, '1, '1);
      run_random(PHASE_ITEMS);

      // All zero, including the amplitude factor.
      wait_idle();
      program_coefs('0, '0, '0, '0, '0, '0, '0);
      run_random(PHASE_ITEMS);

      // Arbitrary 32-bit coefficients.
      wait_idle();
      program_coefs($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                    $urandom());
      run_random(PHASE_ITEMS);

      // Realistic spacings and a factor between zero and three, so rounding is exercised
      // without saturation hiding it.
      wait_idle();
      program_coefs($urandom_range(0, 32'h4_0000), $urandom_range(0, 32'h4_0000),
                    $urandom_range(0, 32'h4_0000), $urandom_range(0, 32'h2_0000),
                    $urandom_range(0, 32'h2_0000), $urandom_range(0, 32'h2_0000),
                    $urandom_range(0, 32'h3_0000));
      run_random(PHASE_ITEMS);

      // Amplitude factor below one: only its fractional half is set.
      wait_idle();
      program_coefs(INV_SQ_RESET, $urandom_range(1, 32'h2_0000), INV_SQ_RESET,
                    HALF_INV_RESET, $urandom_range(1, 32'h1_0000), HALF_INV_RESET,
                    $urandom_range(0, 32'hFFFF));
      run_random(PHASE_ITEMS);

      wait_idle();
      if (mismatches == 0 && owed == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // Roughly ten times the slowest legal run.
   initial begin
      #10ms;
      $display("FAILURE");
      $finish;
   end

endmodule
